// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros shared by the RTL; they vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/fp32ri_pkg.sv
// ---------------------------------------------------------------------------
// fp32ri_pkg
// Shared types and constants for the single-precision round-to-integral core.
// ---------------------------------------------------------------------------
`default_nettype none
package fp32ri_pkg;
    localparam int unsigned CmdWidth = 2;
    localparam int unsigned WordWidth = 32;
    localparam logic [CmdWidth-1:0] CMD_FLOOR = 2'd0;
    localparam logic [CmdWidth-1:0] CMD_CEIL = 2'd1;
    localparam logic [CmdWidth-1:0] CMD_MODF = 2'd2;
    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
    localparam logic [7:0] EXP_BIAS = 8'd127;
    localparam int unsigned MANT_BITS = 23;

    typedef struct packed {
        logic [31:0] whole;
        logic [31:0] fraction;
    } result_t;
endpackage
`default_nettype wire

// File: rtl/core/fp32ri_datapath.sv
// ---------------------------------------------------------------------------
// fp32ri_datapath
// Combinational floor, ceil and modf on one single-precision pattern.
// ---------------------------------------------------------------------------
`default_nettype none
module fp32ri_datapath (
    input  wire logic [1:0]          command,
    input  wire logic [31:0]         operand_bits,
    output fp32ri_pkg::result_t      result
);
    logic        sgn;
    logic [7:0]  expf;
    logic [8:0]  e_s;          // exponent minus bias, two's complement
    logic [4:0]  sh;
    logic [31:0] low_mask;
    logic [31:0] fbits;
    logic [31:0] trunc;
    logic [23:0] mag;
    logic [24:0] mag_inc;
    logic [31:0] bumped;
    logic [4:0]  lz;           // leading zeros of fbits within 23 bits
    logic [22:0] fnorm;
    logic [7:0]  fexp;
    logic        fbits_nz;
    logic        is_zero;

    assign sgn = operand_bits[31];
    assign expf = operand_bits[30:23];
    assign e_s = {1'b0, expf} - {1'b0, fp32ri_pkg::EXP_BIAS};
    assign sh = 5'(5'd23 - e_s[4:0]);
    assign low_mask = (32'd1 << sh) - 32'd1;
    assign fbits = operand_bits & low_mask;
    assign trunc = operand_bits & ~low_mask;
    assign mag = {1'b1, operand_bits[22:0]} >> sh;
    assign mag_inc = {1'b0, mag} + 25'd1;
    assign fbits_nz = fbits != 32'd0;
    assign is_zero = operand_bits[30:0] == 31'd0;

    // mag+1 either stays below 2^(24-sh) or is exactly 2^(24-sh); it rises
    // one binade only when it becomes a power of two beyond mag's range.
    always_comb
    begin
        if (mag_inc[5'(24) - sh] && sh != 5'd0)
            bumped = {sgn, 8'(expf + 8'd1), 23'd0};
        else if (mag_inc[24])
            bumped = {sgn, 8'(expf + 8'd1), 23'd0};
        else
            bumped = {sgn, expf, 23'(mag_inc[22:0] << sh)};
    end

    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (fbits[i])
                lz = 5'(22 - i);
        end
    end

    assign fnorm = 23'(fbits[22:0] << (lz + 5'd1));
    assign fexp = 8'(expf - 8'd1 - {3'd0, lz});

    always_comb
    begin
        result.whole = 32'd0;
        result.fraction = 32'd0;
        if (is_zero)
        begin
            result.whole = 32'd0;
        end
        else if (!e_s[8] && e_s[7:0] > 8'd23)
        begin
            result.whole = operand_bits;
        end
        else if (e_s[8])
        begin
            case (command)
                fp32ri_pkg::CMD_FLOOR:
                    result.whole = sgn ? (fp32ri_pkg::SIGN_MASK | fp32ri_pkg::ONE_BITS)
                                       : 32'd0;
                fp32ri_pkg::CMD_CEIL:
                    result.whole = sgn ? 32'd0 : fp32ri_pkg::ONE_BITS;
                default:
                    result.fraction = operand_bits;
            endcase
        end
        else
        begin
            case (command)
                fp32ri_pkg::CMD_FLOOR:
                    result.whole = (sgn && fbits_nz) ? bumped : trunc;
                fp32ri_pkg::CMD_CEIL:
                    result.whole = (!sgn && fbits_nz) ? bumped : trunc;
                default:
                begin
                    result.whole = trunc;
                    result.fraction = fbits_nz ? {sgn, fexp, fnorm} : 32'd0;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/fp32_round_to_integral_core.sv
// Each accepted input is registered, then its result is registered onto m_axis.
// Throughput: one transaction per cycle unless stalled; input register, rounding
// logic and output register form a two-stage pipeline with full back-pressure.
// Reset: rst_n clears both stage valid flags asynchronously; data needs no reset.
// ---------------------------------------------------------------------------
// fp32_round_to_integral_core
// Single-precision floor, ceil and modf with a streaming interface.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fp32_round_to_integral_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [1:0] command, [33:2] operand_bits
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata    // [31:0] whole_bits, [63:32] fraction_bits
);
    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] opnd_reg;
    logic        out_valid_reg;
    fp32ri_pkg::result_t res_reg;
    fp32ri_pkg::result_t res_next;
    logic        out_ready;
    logic        in_ready;

    // The output stage takes a new result when it is empty or being drained.
    assign out_ready = !out_valid_reg || m_axis_tready;
    // The input stage frees up whenever its content moves on.
    assign in_ready = !in_valid_reg || out_ready;
    assign s_axis_tready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
        begin
            cmd_reg <= s_axis_tdata[1:0];
            opnd_reg <= s_axis_tdata[33:2];
        end
    end

    fp32ri_datapath u_datapath (
        .command      (cmd_reg),
        .operand_bits (opnd_reg),
        .result       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && in_valid_reg)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {res_reg.fraction, res_reg.whole};

    // A result not taken by the sink must stay put.
    `ASSERT_IMPL(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        ##1 (m_axis_tvalid && $stable(m_axis_tdata)))
    // Floor and ceil never produce a fraction.
    `ASSERT_IMPL(a_nofrac, clk, rst_n,
        out_ready && in_valid_reg && (cmd_reg == fp32ri_pkg::CMD_FLOOR ||
        cmd_reg == fp32ri_pkg::CMD_CEIL), ##1 (res_reg.fraction == 32'd0))
    // The input side stalls only behind a stalled, full output.
    `ASSERT_IMPL(a_stall, clk, rst_n, !s_axis_tready,
        in_valid_reg && m_axis_tvalid && !m_axis_tready)
endmodule
`default_nettype wire

// File: sim/tb_fp32_round_to_integral_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_fp32_round_to_integral_core
// Self-checking bench for the single-precision floor, ceil and modf core.
// Operands and commands go in through a stream driver. A bit-level predictor
// computes each result, and a monitor compares every result transaction with
// the oldest prediction. The bench runs three flow-control phases.
// ---------------------------------------------------------------------------
module tb_fp32_round_to_integral_core;

    localparam int unsigned StallLimit = 2000;
    localparam int unsigned RandomItems = 1800;
    // The unused command value, which the core treats as modf.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [1:0] command, [33:2] operand_bits
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [31:0] whole_bits, [63:32] fraction_bits

    logic [39:0]             pending_ops[$];
    fp32ri_pkg::result_t     rounded_q[$];
    int unsigned             src_idle_pct;
    int unsigned             sink_idle_pct;
    bit                      hold_src;
    int unsigned             mismatches;
    int unsigned             results_seen;
    int unsigned             quiet_cycles;

    fp32_round_to_integral_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Renormalize magnitude m times 2^k into a normal single.
    function automatic logic [31:0] normalize_value(logic [31:0] sign, logic [31:0] m,
                                                    int k);
        int          msb;
        logic [31:0] mant;
        msb = 0;
        for (int i = 0; i < 32; i++)
            if (m[i])
                msb = i;
        if (msb > 23)
            mant = m >> (msb - 23);
        else
            mant = m << (23 - msb);
        return sign | (32'(msb + k + 127) << 23) | (mant & 32'h007F_FFFF);
    endfunction

    function automatic fp32ri_pkg::result_t round_operand(logic [1:0] cmd, logic [31:0] a);
        fp32ri_pkg::result_t r;
        logic [31:0] sign;
        logic [31:0] low;
        logic [31:0] fbits;
        logic [31:0] trunc;
        logic [31:0] mag;
        int          expf;
        int          e;
        int          sh;
        r = '0;
        sign = a & fp32ri_pkg::SIGN_MASK;
        expf = int'(a[30:23]);
        e = expf - 127;
        if (a[30:0] == 31'd0)
            r = '0;
        else if (e > 23)
            r.whole = a;
        else if (e < 0)
        begin
            if (cmd == fp32ri_pkg::CMD_FLOOR)
                r.whole = (sign != 0) ? (fp32ri_pkg::SIGN_MASK | fp32ri_pkg::ONE_BITS)
                                      : 32'd0;
            else if (cmd == fp32ri_pkg::CMD_CEIL)
                r.whole = (sign != 0) ? 32'd0 : fp32ri_pkg::ONE_BITS;
            else
                r.fraction = a;
        end
        else
        begin
            sh = 23 - e;
            low = (32'd1 << sh) - 32'd1;
            fbits = a & low;
            trunc = a & ~low;
            mag = ({9'd0, a[22:0]} | 32'h0080_0000) >> sh;
            if (cmd == fp32ri_pkg::CMD_FLOOR)
                r.whole = (sign != 0 && fbits != 0) ? normalize_value(sign, mag + 1, 0)
                                                    : trunc;
            else if (cmd == fp32ri_pkg::CMD_CEIL)
                r.whole = (sign == 0 && fbits != 0) ? normalize_value(32'd0, mag + 1, 0)
                                                    : trunc;
            else
            begin
                r.whole = trunc;
                r.fraction = (fbits != 0) ? normalize_value(sign, fbits, expf - 150)
                                          : 32'd0;
            end
        end
        return r;
    endfunction

    // Pick an operand: mostly exponents around the interesting window.
    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v[30:23] = 8'(127 + $urandom_range(0, 24));
            5:             v[30:23] = 8'(127 - $urandom_range(1, 5));
            6:             v[30:23] = 8'hFF;
            7:             v[30:23] = 8'h00;
            8:             v[22:0] = v[22:0] & (23'h7F_FFFF << $urandom_range(0, 23));
            default: ;
        endcase
        return v;
    endfunction

    // Driver: the front of the pending queue is the transaction on the bus
    // while tvalid is high; it is held until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                rounded_q.push_back(round_operand(s_axis_tdata[1:0], s_axis_tdata[33:2]));
                void'(pending_ops.pop_front());
            end
            if (pending_ops.size() > 0 && !hold_src &&
                $urandom_range(0, 99) >= src_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_ops[0];
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        fp32ri_pkg::result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (rounded_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %h", m_axis_tdata);
                end
                else
                begin
                    want = rounded_q.pop_front();
                    if (m_axis_tdata[31:0] !== want.whole ||
                        m_axis_tdata[63:32] !== want.fraction)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: whole exp %h got %h, fraction exp %h got %h",
                                     want.whole, m_axis_tdata[31:0],
                                     want.fraction, m_axis_tdata[63:32]);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog on cycles with no accepted transaction.
    always @(posedge clk)
    begin
        if (quiet_cycles >= StallLimit)
        begin
            $display("tb_fp32_round_to_integral_core failed");
            $finish;
        end
    end

    task automatic queue_op(logic [1:0] cmd, logic [31:0] a);
        pending_ops.push_back({6'd0, a, cmd});
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || rounded_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] special[12];
        logic [1:0]  cmd;
        rst_n = 1'b0;
        src_idle_pct = 26;
        sink_idle_pct = 49;
        hold_src = 1'b0;
        mismatches = 0;
        results_seen = 0;
        special = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFFC0_0001,
                    32'h0000_0001, 32'h807F_FFFF, 32'h3F00_0000, 32'hBF7F_FFFF,
                    32'h3FC0_0000, 32'hC0A0_0000, 32'h4B7F_FFFF, 32'hCAFF_FFFF};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zeros, an infinity, NaN, denormals, below one, integral values,
        // the largest exponent that still has a fraction; unused command three too.
        for (int i = 0; i < 12; i++)
            queue_op(2'(i % 4), special[i]);
        queue_op(fp32ri_pkg::CMD_FLOOR, 32'hFFFF_FFFF);
        queue_op(fp32ri_pkg::CMD_CEIL, 32'hBF80_0001);
        queue_op(fp32ri_pkg::CMD_MODF, 32'hC0490FDB);
        queue_op(fp32ri_pkg::CMD_FLOOR, 32'hC0490FDB);
        queue_op(fp32ri_pkg::CMD_CEIL, 32'h4049_0FDB);
        queue_op(CMD_SPARE, 32'h4049_0FDB);

        for (int n = 0; n < RandomItems; n++)
        begin
            if (n == RandomItems / 3)
            begin
                // Wait until the pipeline has fully drained, then hold the sender.
                wait_drained();
                hold_src = 1'b1;
                repeat (5) @(posedge clk);
                hold_src = 1'b0;
                src_idle_pct = 49;
                sink_idle_pct = 26;
            end
            else if (n == 2 * RandomItems / 3)
            begin
                wait_drained();
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            cmd = ($urandom_range(0, 15) == 0) ? CMD_SPARE : 2'($urandom_range(0, 2));
            queue_op(cmd, random_operand());
        end
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Covered %0d results: floor, ceil and modf over zeros, NaN, infinities,",
                 results_seen);
        $display("denormals, sub-one and integral values, under three flow-control phases.");
        if (mismatches == 0 && rounded_q.size() == 0)
            $display("tb_fp32_round_to_integral_core passed");
        else
            $display("tb_fp32_round_to_integral_core failed");
        $finish;
    end
endmodule
